@@ sv/assert_macros.svh @@
// assertion macros shared by the md2 hash engine rtl
// no dependencies; assertions drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_DEF(label, prop, msg) `ASSERT_AT(label, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_AT(label, clk, rstn, prop, msg)
`define ASSERT_DEF(label, prop, msg)
`endif
`endif

@@ sv/md2_pkg.sv @@
// md2 hash engine package: sizes, beat types, state ram request and the md2 s-box
// used by md2_mix_ram and md2_hash_engine_top
package md2_pkg;

  localparam int unsigned ROUNDS      = 18;
  localparam int unsigned STATE_BYTES = 48;
  localparam int unsigned BLOCK_BYTES = 16;
  localparam int unsigned SBOX_SIZE   = 256;

  localparam int unsigned ADDR_W  = $clog2(STATE_BYTES);
  localparam int unsigned ROUND_W = $clog2(ROUNDS);
  localparam int unsigned IDX_W   = $clog2(BLOCK_BYTES);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              clr;
  } ram_req_t;

  localparam logic [7:0] SBOX [SBOX_SIZE] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

endpackage

@@ sv/md2_mix_ram.sv @@
// 48-byte md2 compression state ram, one write and one registered read per cycle
// uses md2_pkg and assert_macros.svh; per-entry valid flags make unwritten entries read zero
`include "assert_macros.svh"

module md2_mix_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md2_pkg::ram_req_t req_i,
  output logic [7:0]        rdata_o
);

  logic [7:0]                       mem_q [md2_pkg::STATE_BYTES];
  logic [md2_pkg::STATE_BYTES-1:0]  vld_q;
  logic [md2_pkg::STATE_BYTES-1:0]  vld_d;
  logic [7:0]                       rdata_q;
  logic                             rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (req_i.clr) begin
      vld_d = '0;
    end else if (req_i.we) begin
      vld_d[req_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // entries never written since the last clear read as zero
  assign rdata_o = rvld_q ? rdata_q : 8'd0;

  `ASSERT_DEF(a_no_write_on_clear, !(req_i.we && req_i.clr), "state ram written during clear")

endmodule

@@ sv/md2_hash_engine_top.sv @@
// md2 hash engine top level: byte input, block buffer, checksum and round sequencer
// uses md2_pkg, md2_mix_ram and assert_macros.svh
`include "assert_macros.svh"

// Takes a message one byte per beat and returns the 16-byte md2 digest as 16 output beats,
// first byte first, digest_last on the final one. A beat that neither completes a block nor
// ends the message leaves the engine idle for the next beat. A beat that completes a 16-byte
// block starts the compression, which runs one s-box lookup per cycle through the 48-byte
// state ram: a priming read of the ram and then 18 x 48 = 864 steps, with the checksum
// update riding along in the first 16 steps. An end beat leads to a padding step, a block
// compression and a checksum compression, then each digest byte takes a ram read and is
// held until its output beat is taken. No input is taken from a completed block until the
// engine is idle again. Reset needs no clearing pass: the state ram keeps a valid flag per
// entry and is cleared after each digest.
module md2_hash_engine_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  md2_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output md2_pkg::out_item_t out_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_RUN   = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  localparam logic [md2_pkg::ADDR_W-1:0]  K_LAST =
    md2_pkg::ADDR_W'(md2_pkg::STATE_BYTES - 1);
  localparam logic [md2_pkg::ROUND_W-1:0] R_LAST =
    md2_pkg::ROUND_W'(md2_pkg::ROUNDS - 1);
  localparam logic [md2_pkg::IDX_W-1:0]   IDX_LAST =
    md2_pkg::IDX_W'(md2_pkg::BLOCK_BYTES - 1);

  logic [2:0] state_q, state_d;
  logic [md2_pkg::IDX_W-1:0]   fill_q, fill_d;
  logic [md2_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic [md2_pkg::ADDR_W-1:0]  k_q, k_d;
  logic [md2_pkg::ROUND_W-1:0] r_q, r_d;
  logic [7:0] t_q, t_d;
  logic [7:0] carry_q, carry_d;
  logic       chk_mode_q, chk_mode_d;
  logic       end_pend_q, end_pend_d;
  logic       padded_q, padded_d;
  logic       out_valid_q, out_valid_d;
  logic       last_q, last_d;

  logic [7:0] buf_q  [md2_pkg::BLOCK_BYTES];
  logic [7:0] buf_d  [md2_pkg::BLOCK_BYTES];
  logic [7:0] side_q [md2_pkg::BLOCK_BYTES];
  logic [7:0] side_d [md2_pkg::BLOCK_BYTES];
  logic [7:0] chk_q  [md2_pkg::BLOCK_BYTES];
  logic [7:0] chk_d  [md2_pkg::BLOCK_BYTES];

  md2_pkg::ram_req_t ram_req;
  logic [7:0] ram_rdata;

  logic [md2_pkg::IDX_W-1:0] k_lo;
  logic [7:0] blk_byte;
  logic [7:0] x_cur;
  logic [7:0] t_new;
  logic [7:0] chk_new;
  logic [7:0] pad_val;
  logic       in_beat;
  logic       step_done;

  md2_mix_ram u_mix_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign in_beat   = in_valid_i && in_ready_o;
  assign k_lo      = k_q[md2_pkg::IDX_W-1:0];
  assign blk_byte  = chk_mode_q ? chk_q[k_lo] : buf_q[k_lo];
  assign step_done = (k_q == K_LAST) && (r_q == R_LAST);
  assign pad_val   = 8'(md2_pkg::BLOCK_BYTES) - {4'd0, fill_q};

  // round 0 builds the upper two thirds of the state on the fly:
  // bytes 16..31 are the block, bytes 32..47 the block xor the old low third
  always_comb begin
    x_cur = ram_rdata;
    if (r_q == '0) begin
      case (k_q[md2_pkg::ADDR_W-1:md2_pkg::IDX_W])
        2'd1:    x_cur = blk_byte;
        2'd2:    x_cur = side_q[k_lo];
        default: x_cur = ram_rdata;
      endcase
    end
  end

  assign t_new   = x_cur ^ md2_pkg::SBOX[t_q];
  assign chk_new = chk_q[k_lo] ^ md2_pkg::SBOX[buf_q[k_lo] ^ carry_q];

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    k_d         = k_q;
    r_d         = r_q;
    t_d         = t_q;
    carry_d     = carry_q;
    chk_mode_d  = chk_mode_q;
    end_pend_d  = end_pend_q;
    padded_d    = padded_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    buf_d       = buf_q;
    side_d      = side_q;
    chk_d       = chk_q;
    ram_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          if (in_i.byte_present) begin
            buf_d[fill_q] = in_i.data_byte;
            if (fill_q == IDX_LAST) begin
              fill_d     = '0;
              end_pend_d = in_i.end_of_message;
              padded_d   = 1'b0;
              chk_mode_d = 1'b0;
              state_d    = S_PRIME;
            end else begin
              fill_d = fill_q + 1'b1;
              if (in_i.end_of_message) begin
                end_pend_d = 1'b1;
                state_d    = S_PAD;
              end
            end
          end else if (in_i.end_of_message) begin
            end_pend_d = 1'b1;
            state_d    = S_PAD;
          end
        end
      end
      S_PAD: begin
        for (int j = 0; j < md2_pkg::BLOCK_BYTES; j++) begin
          if (md2_pkg::IDX_W'(j) >= fill_q) begin
            buf_d[j] = pad_val;
          end
        end
        padded_d   = 1'b1;
        chk_mode_d = 1'b0;
        state_d    = S_PRIME;
      end
      S_PRIME: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = '0;
        k_d           = '0;
        r_d           = '0;
        t_d           = 8'd0;
        state_d       = S_RUN;
      end
      S_RUN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = k_q;
        ram_req.wdata = t_new;
        ram_req.re    = !step_done;
        ram_req.raddr = (k_q == K_LAST) ? '0 : k_q + 1'b1;
        if ((r_q == '0) && (k_q[md2_pkg::ADDR_W-1:md2_pkg::IDX_W] == 2'd0)) begin
          side_d[k_lo] = blk_byte ^ ram_rdata;
          if (!chk_mode_q) begin
            chk_d[k_lo] = chk_new;
            carry_d     = chk_new;
          end
        end
        if (k_q == K_LAST) begin
          k_d = '0;
          r_d = r_q + 1'b1;
          t_d = t_new + {3'd0, r_q};
        end else begin
          k_d = k_q + 1'b1;
          t_d = t_new;
        end
        if (step_done) begin
          if (chk_mode_q) begin
            idx_d   = '0;
            state_d = S_FETCH;
          end else if (!end_pend_q) begin
            state_d = S_IDLE;
          end else if (!padded_q) begin
            state_d = S_PAD;
          end else begin
            chk_mode_d = 1'b1;
            state_d    = S_PRIME;
          end
        end
      end
      S_FETCH: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = {2'd0, idx_q};
        out_valid_d   = 1'b1;
        last_d        = (idx_q == IDX_LAST);
        state_d       = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            // digest done: back to the reset state for the next message
            ram_req.clr = 1'b1;
            fill_d      = '0;
            carry_d     = 8'd0;
            chk_mode_d  = 1'b0;
            end_pend_d  = 1'b0;
            padded_d    = 1'b0;
            for (int j = 0; j < md2_pkg::BLOCK_BYTES; j++) begin
              chk_d[j] = 8'd0;
            end
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_FETCH;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    side_q <= side_d;
    k_q    <= k_d;
    r_q    <= r_d;
    t_q    <= t_d;
    idx_q  <= idx_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      carry_q     <= 8'd0;
      chk_mode_q  <= 1'b0;
      end_pend_q  <= 1'b0;
      padded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < md2_pkg::BLOCK_BYTES; j++) begin
        chk_q[j] <= 8'd0;
      end
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      carry_q     <= carry_d;
      chk_mode_q  <= chk_mode_d;
      end_pend_q  <= end_pend_d;
      padded_q    <= padded_d;
      out_valid_q <= out_valid_d;
      chk_q       <= chk_d;
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign out_o.digest_byte = ram_rdata;
  assign out_o.digest_last = last_q;

  `ASSERT_DEF(a_in_out_exclusive, !(in_ready_o && out_valid_o), "input ready while digest pending")
  `ASSERT_DEF(a_write_only_in_run, ram_req.we |-> (state_q == S_RUN), "state ram write outside rounds")
  `ASSERT_DEF(a_step_bounds, (state_q == S_RUN) |-> ((r_q <= R_LAST) && (k_q <= K_LAST)), "round step out of range")
  `ASSERT_DEF(a_last_beat_clears, (out_valid_o && out_ready_i && out_o.digest_last) |=> ((state_q == S_IDLE) && (fill_q == '0) && (carry_q == 8'd0)), "state not cleared after digest")
  `ASSERT_DEF(a_hold_keeps_read, (state_q == S_HOLD) |-> !ram_req.re, "digest byte overwritten while held")

endmodule
